// ===== src/tmge_pkg.sv =====
package tmge_pkg;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CHAR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_CHAR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEWLINE_CHAR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_CHAR   = 3'd5;

  localparam logic [7:0] CELL_WIDTH_RST   = 8'd8;
  localparam logic [7:0] CELL_HEIGHT_RST  = 8'd12;
  localparam logic [7:0] ESCAPE_CHAR_RST  = 8'd124;
  localparam logic [7:0] RESET_CHAR_RST   = 8'd114;
  localparam logic [7:0] NEWLINE_CHAR_RST = 8'd110;
  localparam logic [7:0] COLOR_CHAR_RST   = 8'd99;

  // Parser modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESCAPE = 2'd1;
  localparam logic [1:0] MODE_HEX    = 2'd2;

  localparam logic [31:0] COLOR_WHITE = 32'hFFFF_FFFF;

  // Color code length and its capture buffer index
  localparam int unsigned HEX_DIGITS = 8;
  localparam int unsigned PEND_IDX_W = $clog2(HEX_DIGITS);

  localparam int unsigned STACK_DEPTH_DEF   = 16;
  localparam int unsigned ATLAS_COLUMNS_DEF = 16;

  typedef struct packed {
    logic [7:0]         char_code;
    logic               is_final;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         glyph;
    logic [11:0]        atlas_x;
    logic [11:0]        atlas_y;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [31:0]        rgba;
    logic               run_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0] cell_width;
    logic [7:0] cell_height;
    logic [7:0] escape_char;
    logic [7:0] reset_char;
    logic [7:0] newline_char;
    logic [7:0] color_char;
  } cfg_regs_t;

  // Controller to datapath
  typedef struct packed {
    logic                  step;     // process one character this cycle
    logic                  src_rep;  // character comes from the capture buffer
    logic [PEND_IDX_W-1:0] rp_idx;
    logic                  last;     // character is the final one of the string
    logic                  seq_end;  // no more characters queued for this word
    logic                  flush;    // send the held glyph as the closing one
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic                  out_free;
    logic                  replay;
    logic [PEND_IDX_W-1:0] rp_last;
    logic                  flush_need;
    logic                  hold_vld;
  } dp_stat_t;

  // Atlas column (want_rem) or row of every code, built by counting
  function automatic logic [2047:0] col_tab(input int cols, input bit want_rem);
    logic [2047:0] tab;
    int q;
    int r;
    tab = '0;
    q = 0;
    r = 0;
    for (int g = 0; g < 256; g++) begin
      tab[g*8 +: 8] = want_rem ? 8'(r) : 8'(q);
      r++;
      if (r == cols) begin
        r = 0;
        q++;
      end
    end
    return tab;
  endfunction

  // {valid, value} of one hex digit character
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// ===== src/text_markup_glyph_emitter_core.sv =====
// Text markup glyph emitter: takes one character per word and returns its glyphs with atlas
// cell origin, screen position and current color; inline escapes select the escape glyph,
// color pop, newline and an RRGGBBAA color push. A character is taken in any cycle in which
// the output register is free, and its glyph sits on the output from the next cycle. When a
// string ends inside a color code, the captured characters, the final one included, are fed
// again through the same single-character parser, one per cycle, followed by the characters
// of any color code cut again inside the replayed text; the word closes with a flush when
// the final replayed character makes a glyph while an earlier one is still held back. No new
// character is taken during replay or flush. A stalled output word holds off both input and
// replay. The color stack below its top entry sits in a memory with a registered read port.
module text_markup_glyph_emitter_core import tmge_pkg::*; #(
  parameter int unsigned STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int unsigned ATLAS_COLUMNS = ATLAS_COLUMNS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i
);

  cfg_regs_t cfg;
  ctl_cmd_t  cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  tmge_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tmge_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_fin_i   (in_data_i.is_final),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  tmge_dp #(
    .STACK_DEPTH   (STACK_DEPTH),
    .ATLAS_COLUMNS (ATLAS_COLUMNS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A new word never starts while a glyph of the previous one is held back
  a_no_accept_with_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !stat.hold_vld)
    else $error("word accepted while a glyph is held");

  // Flush only sends a glyph that is actually held
  a_flush_has_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush |-> stat.hold_vld)
    else $error("flush without held glyph");

  // Replay only starts on the final character of a string
  a_replay_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.step && stat.replay) |-> cmd.last)
    else $error("replay on a non-final character");

endmodule

// ===== src/tmge_cfg.sv =====
module tmge_cfg import tmge_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  output cfg_regs_t            cfg_o
);

  cfg_regs_t regs_q;

  // Register file, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.cell_width   <= CELL_WIDTH_RST;
      regs_q.cell_height  <= CELL_HEIGHT_RST;
      regs_q.escape_char  <= ESCAPE_CHAR_RST;
      regs_q.reset_char   <= RESET_CHAR_RST;
      regs_q.newline_char <= NEWLINE_CHAR_RST;
      regs_q.color_char   <= COLOR_CHAR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CELL_WIDTH:   regs_q.cell_width   <= cfg_data_i;
        REG_CELL_HEIGHT:  regs_q.cell_height  <= cfg_data_i;
        REG_ESCAPE_CHAR:  regs_q.escape_char  <= cfg_data_i;
        REG_RESET_CHAR:   regs_q.reset_char   <= cfg_data_i;
        REG_NEWLINE_CHAR: regs_q.newline_char <= cfg_data_i;
        REG_COLOR_CHAR:   regs_q.color_char   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = regs_q;

endmodule

// ===== src/tmge_ctrl.sv =====
module tmge_ctrl import tmge_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_fin_i,
  input  dp_stat_t  stat_i,
  output ctl_cmd_t  cmd_o,
  output logic      in_stall_o
);

  localparam logic [1:0] ST_RUN    = 2'd0;
  localparam logic [1:0] ST_REPLAY = 2'd1;
  localparam logic [1:0] ST_FLUSH  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [PEND_IDX_W-1:0] rp_idx_q, rp_idx_d;
  logic [PEND_IDX_W-1:0] rp_last_q, rp_last_d;
  logic                  at_rp_last;

  assign at_rp_last = (rp_idx_q == rp_last_q);

  // Commands
  assign in_stall_o     = !((state_q == ST_RUN) && stat_i.out_free);
  assign cmd_o.src_rep  = (state_q == ST_REPLAY);
  assign cmd_o.rp_idx   = rp_idx_q;
  assign cmd_o.step     = stat_i.out_free &&
                          (((state_q == ST_RUN) && in_valid_i) || (state_q == ST_REPLAY));
  assign cmd_o.last     = (state_q == ST_REPLAY) ? at_rp_last : in_fin_i;
  assign cmd_o.seq_end  = (state_q == ST_REPLAY) ? at_rp_last : 1'b1;
  assign cmd_o.flush    = (state_q == ST_FLUSH) && stat_i.out_free;

  // Sequencer: live input, replay of a cut color code, closing flush
  always_comb begin
    state_d   = state_q;
    rp_idx_d  = rp_idx_q;
    rp_last_d = rp_last_q;
    case (state_q)
      ST_RUN, ST_REPLAY: begin
        if (cmd_o.step) begin
          if (stat_i.replay) begin
            state_d   = ST_REPLAY;
            rp_idx_d  = '0;
            rp_last_d = stat_i.rp_last;
          end else if (cmd_o.seq_end) begin
            state_d = stat_i.flush_need ? ST_FLUSH : ST_RUN;
          end else begin
            rp_idx_d = rp_idx_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (cmd_o.flush) state_d = ST_RUN;
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_RUN;
      rp_idx_q  <= '0;
      rp_last_q <= '0;
    end else begin
      state_q   <= state_d;
      rp_idx_q  <= rp_idx_d;
      rp_last_q <= rp_last_d;
    end
  end

endmodule

// ===== src/tmge_dp.sv =====
module tmge_dp import tmge_pkg::*; #(
  parameter int unsigned STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int unsigned ATLAS_COLUMNS = ATLAS_COLUMNS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_regs_t cfg_i,
  input  in_item_t  in_data_i,
  input  ctl_cmd_t  cmd_i,
  output dp_stat_t  stat_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned SW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam logic [2047:0] ROW_TAB = col_tab(ATLAS_COLUMNS, 1'b0);
  localparam logic [2047:0] COL_TAB = col_tab(ATLAS_COLUMNS, 1'b1);

  // Parser and cursor state
  logic [1:0]  mode_q, mode_d;
  logic        active_q, active_d;
  logic [15:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [31:0] top_q, top_d;
  logic [31:0] below_q;
  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] hex_val_q, hex_val_d;
  logic [PEND_IDX_W-1:0] hex_cnt_q, hex_cnt_d;
  logic        stopped_q, stopped_d;
  logic [7:0]  pend_q [HEX_DIGITS];
  logic [15:0] ox_q, oy_q;

  // Glyph staging
  out_item_t   hold_q, out_q, new_g, push_item;
  logic        hold_vld_q, out_vld_q;

  // Step decode
  logic [7:0]  ch;
  logic [15:0] ox, oy;
  logic [1:0]  mode_e;
  logic [DW-1:0] depth_e;
  logic [31:0] top_e;
  logic [15:0] cx_e, cy_e;
  logic        emit, push, pop, replay, finish, pend_we;
  logic        push_room;
  logic [4:0]  nib;
  logic [DW-1:0] wr_full, rd_full;
  logic [SW-1:0] wr_addr, rd_addr;
  logic [7:0]  col_r, row_r;
  logic [15:0] ax_prod, ay_prod;
  logic        item_end, direct, hold_mid, hold_end, push_any, capture, out_free;

  // Character source and string-start view of the state
  assign ch      = cmd_i.src_rep ? pend_q[cmd_i.rp_idx] : in_data_i.char_code;
  assign ox      = cmd_i.src_rep ? ox_q : in_data_i.origin_x;
  assign oy      = cmd_i.src_rep ? oy_q : in_data_i.origin_y;
  assign mode_e  = active_q ? mode_q  : MODE_NORMAL;
  assign depth_e = active_q ? depth_q : DW'(1);
  assign top_e   = active_q ? top_q   : COLOR_WHITE;
  assign cx_e    = active_q ? cur_x_q : ox;
  assign cy_e    = active_q ? cur_y_q : oy;
  assign nib     = hex_nibble(ch);
  assign push_room = (depth_q < DW'(STACK_DEPTH));

  // Parse one character
  always_comb begin
    mode_d    = mode_q;
    active_d  = active_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    depth_d   = depth_q;
    top_d     = top_q;
    hex_val_d = hex_val_q;
    hex_cnt_d = hex_cnt_q;
    stopped_d = stopped_q;
    emit      = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    replay    = 1'b0;
    finish    = 1'b0;
    pend_we   = 1'b0;
    if (cmd_i.step) begin
      active_d = 1'b1;
      mode_d   = MODE_NORMAL;
      depth_d  = depth_e;
      top_d    = top_e;
      cur_x_d  = cx_e;
      cur_y_d  = cy_e;
      case (mode_e)
        MODE_ESCAPE: begin
          if (cmd_i.last) begin
            finish = 1'b1;
          end else if (ch == cfg_i.reset_char) begin
            pop = (depth_e > DW'(1));
          end else if (ch == cfg_i.newline_char) begin
            cur_x_d = ox;
            cur_y_d = cy_e + {8'd0, cfg_i.cell_height};
          end else if (ch == cfg_i.color_char) begin
            mode_d    = MODE_HEX;
            hex_cnt_d = '0;
            hex_val_d = '0;
            stopped_d = 1'b0;
          end else if (ch == cfg_i.escape_char) begin
            emit = 1'b1;
          end
        end
        MODE_HEX: begin
          pend_we   = 1'b1;
          stopped_d = stopped_q | !nib[4];
          if (!stopped_q && nib[4]) hex_val_d = {hex_val_q[27:0], nib[3:0]};
          if (hex_cnt_q == PEND_IDX_W'(HEX_DIGITS - 1)) begin
            push      = 1'b1;
            hex_cnt_d = '0;
            finish    = cmd_i.last;
          end else if (cmd_i.last) begin
            replay    = 1'b1;
            hex_cnt_d = '0;
          end else begin
            mode_d    = MODE_HEX;
            hex_cnt_d = hex_cnt_q + 1'b1;
          end
        end
        default: begin
          if ((ch == cfg_i.escape_char) && !cmd_i.last) begin
            mode_d = MODE_ESCAPE;
          end else begin
            emit   = 1'b1;
            finish = cmd_i.last;
          end
        end
      endcase
      if (emit) cur_x_d = cx_e + {8'd0, cfg_i.cell_width};
      if (pop) begin
        depth_d = depth_q - DW'(1);
        top_d   = below_q;
      end
      if (push) begin
        top_d = hex_val_d;
        if (push_room) depth_d = depth_q + DW'(1);
      end
      if (finish) begin
        active_d  = 1'b0;
        mode_d    = MODE_NORMAL;
        hex_cnt_d = '0;
      end
    end
  end

  // Color stack below the top entry
  assign wr_full = depth_q - DW'(1);
  assign rd_full = depth_q - DW'(3);
  assign wr_addr = wr_full[SW-1:0];
  assign rd_addr = rd_full[SW-1:0];

  always_ff @(posedge clk_i) begin
    if (push && push_room) begin
      stack_mem[wr_addr] <= top_q;
      below_q            <= top_q;
    end else if (pop) begin
      below_q <= stack_mem[rd_addr];
    end
  end

  // Color digit capture, replayed in place
  always_ff @(posedge clk_i) begin
    if (pend_we) pend_q[hex_cnt_q] <= ch;
    if (cmd_i.step && !cmd_i.src_rep) begin
      ox_q <= in_data_i.origin_x;
      oy_q <= in_data_i.origin_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NORMAL;
      active_q  <= 1'b0;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      depth_q   <= DW'(1);
      top_q     <= COLOR_WHITE;
      hex_val_q <= '0;
      hex_cnt_q <= '0;
      stopped_q <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      active_q  <= active_d;
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      depth_q   <= depth_d;
      top_q     <= top_d;
      hex_val_q <= hex_val_d;
      hex_cnt_q <= hex_cnt_d;
      stopped_q <= stopped_d;
    end
  end

  // Glyph fields
  assign col_r   = COL_TAB[{ch, 3'b000} +: 8];
  assign row_r   = ROW_TAB[{ch, 3'b000} +: 8];
  assign ax_prod = {8'd0, col_r} * {8'd0, cfg_i.cell_width};
  assign ay_prod = {8'd0, row_r} * {8'd0, cfg_i.cell_height};

  always_comb begin
    new_g.glyph    = ch;
    new_g.atlas_x  = ax_prod[11:0];
    new_g.atlas_y  = ay_prod[11:0];
    new_g.screen_x = cx_e;
    new_g.screen_y = cy_e;
    new_g.rgba     = top_e;
    new_g.run_end  = 1'b0;
  end

  // A glyph is held back until it is known whether it closes the word
  assign item_end = cmd_i.step && cmd_i.seq_end && !replay;
  assign direct   = emit && item_end && !hold_vld_q;
  assign hold_mid = emit && hold_vld_q;
  assign hold_end = item_end && !emit && hold_vld_q;
  assign capture  = emit && !direct;
  assign push_any = direct || hold_mid || hold_end || cmd_i.flush;
  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    push_item = hold_q;
    if (direct) begin
      push_item         = new_g;
      push_item.run_end = 1'b1;
    end else begin
      push_item.run_end = !hold_mid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture)  hold_q <= new_g;
    if (push_any) out_q  <= push_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (capture)                       hold_vld_q <= 1'b1;
      else if (hold_end || cmd_i.flush)  hold_vld_q <= 1'b0;
      if (push_any)                      out_vld_q  <= 1'b1;
      else if (!out_stall_i)             out_vld_q  <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Status
  assign stat_o.out_free   = out_free;
  assign stat_o.replay     = replay;
  assign stat_o.rp_last    = hex_cnt_q;
  assign stat_o.flush_need = hold_mid && item_end;
  assign stat_o.hold_vld   = hold_vld_q;

endmodule
